>>> sv/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB page table translator package
// Field widths and parameter defaults shared by the translator core.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int ADDR_W  = 16;
  localparam int FRAME_W = 8;
  localparam int CNT_W   = 32;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;
  localparam int PAGE_BYTES_DEF  = 256;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // output tdata: physical_address, hit_total, fault_total, padded to bytes
  localparam int OUT_BITS   = ADDR_W + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [0:0] {
    USER_HIT   = 1'b0,
    USER_FAULT = 1'b1
  } user_bit_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> sv/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tlb_page_table_translator_core.sv
// ----------------------------------------------------------------------------
// TLB page table translator core
// Input is held in the stage register, the result in the output register.
// Throughput: one address per cycle unless the output stalls; page table RAM
// read as the address is taken; TLB, valid bits, counters update in one pass.
// Reset (synchronous): empties TLB and page table valid bits, clears the FIFO
// pointer, free frame counter and hit/fault counts. No clearing pass.
// PAGE_BYTES and PAGE_COUNT must be powers of two.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_core
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,   // [15:0] logical_address
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] physical_address,
                                                // [47:16] hit_total,
                                                // [79:48] fault_total
  output logic [1:0]            m_axis_tuser    // [0] tlb_hit, [1] page_fault
);

  localparam int OFS_W   = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int TLB_IW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [TLB_IW-1:0] TLB_LAST = TLB_IW'(TLB_ENTRIES - 1);

  // TLB and mapping state
  logic                  tlb_valid [TLB_ENTRIES];
  logic [PAGE_W-1:0]     tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]    tlb_frame [TLB_ENTRIES];
  logic [PAGE_COUNT-1:0] table_valid;
  logic [TLB_IW-1:0]     fifo_pointer;
  logic [FRAME_W-1:0]    next_free_frame;
  logic [CNT_W-1:0]      hit_counter;
  logic [CNT_W-1:0]      fault_counter;

  // input stage
  logic                  stage_valid;
  logic [ADDR_W-1:0]     stage_addr;
  logic                  fwd;
  logic [FRAME_W-1:0]    fwd_frame;

  // output register
  logic                  out_valid;
  logic [ADDR_W-1:0]     out_phys;
  logic                  out_hit;
  logic                  out_fault;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_fault_total;

  logic                  fire;
  logic                  load;
  logic [ADDR_W-1:0]     in_shift;
  logic [PAGE_W-1:0]     in_page;
  logic [ADDR_W-1:0]     stage_shift;
  logic [PAGE_W-1:0]     stage_page;
  logic [OFS_W-1:0]      stage_ofs;
  logic [TLB_ENTRIES-1:0] match;
  logic                  hit;
  logic [FRAME_W-1:0]    hit_frame;
  logic                  mapped;
  logic [FRAME_W-1:0]    ram_rdata;
  logic [FRAME_W-1:0]    table_frame;
  logic [FRAME_W-1:0]    frame;
  logic                  fault;
  logic [PAGE_W-1:0]     ram_raddr;
  logic                  ram_we;
  logic [CNT_W-1:0]      hit_counter_next;
  logic [CNT_W-1:0]      fault_counter_next;
  logic [ADDR_W-1:0]     phys;

  // handshake
  assign fire          = stage_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !stage_valid || fire;
  assign load          = s_axis_tvalid && s_axis_tready;

  // address split
  assign in_shift    = s_axis_tdata >> OFS_W;
  assign in_page     = in_shift[PAGE_W-1:0];
  assign stage_shift = stage_addr >> OFS_W;
  assign stage_page  = stage_shift[PAGE_W-1:0];
  assign stage_ofs   = stage_addr[OFS_W-1:0];

  // TLB search, lowest matching entry wins
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tlb_valid[i] && (tlb_page[i] == stage_page);
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit       = 1'b1;
        hit_frame = tlb_frame[i];
      end
    end
  end

  // page table
  assign ram_raddr   = load ? in_page : stage_page;
  assign mapped      = table_valid[stage_page];
  assign table_frame = fwd ? fwd_frame : ram_rdata;
  assign fault       = !hit && !mapped;
  assign ram_we      = fire && fault;

  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stage_page),
    .wdata (next_free_frame),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    priority if (hit) begin
      frame = hit_frame;
    end else if (mapped) begin
      frame = table_frame;
    end else begin
      frame = next_free_frame;
    end
  end

  assign phys               = ADDR_W'({frame, stage_ofs});
  assign hit_counter_next   = hit ? sat_inc(hit_counter) : hit_counter;
  assign fault_counter_next = fault ? sat_inc(fault_counter) : fault_counter;

  // stage and bypass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      fwd         <= 1'b0;
    end else begin
      if (load) begin
        stage_valid <= 1'b1;
      end else if (fire) begin
        stage_valid <= 1'b0;
      end
      fwd <= ram_we && (stage_page == ram_raddr);
    end
    if (load) begin
      stage_addr <= s_axis_tdata;
    end
    fwd_frame <= next_free_frame;
  end

  // translation state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid[i] <= 1'b0;
      end
      table_valid     <= '0;
      fifo_pointer    <= '0;
      next_free_frame <= '0;
      hit_counter     <= '0;
      fault_counter   <= '0;
    end else if (fire) begin
      hit_counter   <= hit_counter_next;
      fault_counter <= fault_counter_next;
      if (!hit) begin
        tlb_valid[fifo_pointer] <= 1'b1;
        fifo_pointer <= (fifo_pointer == TLB_LAST) ? '0 : fifo_pointer + TLB_IW'(1);
      end
      if (fault) begin
        table_valid[stage_page] <= 1'b1;
        next_free_frame         <= next_free_frame + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hit) begin
      tlb_page[fifo_pointer]  <= stage_page;
      tlb_frame[fifo_pointer] <= frame;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_phys        <= phys;
      out_hit         <= hit;
      out_fault       <= fault;
      out_hit_total   <= hit_counter_next;
      out_fault_total <= fault_counter_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_fault_total, out_hit_total, out_phys});

  always_comb begin
    m_axis_tuser           = '0;
    m_axis_tuser[USER_HIT]   = out_hit;
    m_axis_tuser[USER_FAULT] = out_fault;
  end

endmodule
